// File: rtl/lli_pkg.sv
// Package for the LUT linear interpolator: item structs, codes, widths,
// controller state and the command and status groups between the modules.
// Depends on nothing; every other file but lli_ram refers to it by scoped names.
package lli_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int FW = 24;
  localparam int TW = 24;
  localparam int QW = FW + 1;
  localparam int NW = 2 * QW;
  localparam int RAM_W = FW + TW;
  localparam int CNT_W = 7;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CONV = 1'b1;

  localparam logic [1:0] STATUS_CONV = 2'd0;
  localparam logic [1:0] STATUS_OOR  = 2'd1;
  localparam logic [1:0] STATUS_LOAD = 2'd2;

  localparam logic CFG_ENTRY_COUNT = 1'b0;
  localparam logic CFG_SLOPE       = 1'b1;

  localparam logic [CNT_W-1:0] COUNT_RESET = 7'd2;

  typedef struct packed {
    logic                 opcode;
    logic [5:0]           entry_index;
    logic [FW-1:0]        point_from;
    logic signed [TW-1:0] point_to;
    logic [FW-1:0]        measured_value;
  } lli_in_t;

  typedef struct packed {
    logic signed [TW-1:0] converted_value;
    logic [1:0]           status;
  } lli_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST,
    ST_FIRST,
    ST_CHK0,
    ST_SCAN,
    ST_MUL,
    ST_DSTART,
    ST_DIV
  } lli_state_t;

  typedef enum logic [1:0] {
    ADDR_LAST,
    ADDR_ZERO,
    ADDR_IDX
  } lli_addr_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_LOAD,
    RES_OOR,
    RES_CONV
  } lli_res_t;

  typedef struct packed {
    logic      cap;
    logic      ld_wr;
    lli_addr_t addr_sel;
    logic      chk_hi;
    logic      step;
    logic      grab;
    logic      mul;
    logic      div_start;
    lli_res_t  emit;
  } lli_cmd_t;

  typedef struct packed {
    logic oor;
    logic hit;
    logic at_last;
    logic div_done;
  } lli_stat_t;

endpackage

// File: rtl/lli_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module lli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lli_div.sv
// Serial signed divider, one quotient bit a cycle, truncating toward zero.
// Depends on lli_pkg; the quotient magnitude must fit in QW bits.
module lli_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [lli_pkg::NW-1:0]   num,
  input  logic signed [lli_pkg::QW-1:0]   den,
  output logic                            done,
  output logic signed [lli_pkg::QW-1:0]   quo
);

  localparam int QW = lli_pkg::QW;
  localparam int NW = lli_pkg::NW;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] lo_r, lo_nxt;
  logic [QW-1:0] b_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic          neg_r;
  logic [NW-1:0] mag_a;
  logic [QW-1:0] mag_b;
  logic [QW:0]   trial;
  logic          ge;

  assign mag_a = num[NW-1] ? NW'(-num) : NW'(num);
  assign mag_b = den[QW-1] ? QW'(-den) : QW'(den);
  assign trial = {rem_r, lo_r[QW-1]} - {1'b0, b_r};
  assign ge    = ~trial[QW];

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = mag_a[NW-1:QW];
      lo_nxt  = mag_a[QW-1:0];
      cnt_nxt = CW'(QW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? trial[QW-1:0] : {rem_r[QW-2:0], lo_r[QW-1]};
      lo_nxt  = {lo_r[QW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    if (start) begin
      b_r   <= mag_b;
      neg_r <= num[NW-1] ^ den[QW-1];
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? QW'(-$signed(lo_r)) : $signed(lo_r);

endmodule

// File: rtl/lli_dp.sv
// Datapath of the interpolator: configuration registers, breakpoint RAM,
// search compares, segment registers, multiplier, divider and result register.
// Depends on lli_pkg, lli_ram and lli_div.
module lli_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lli_pkg::lli_in_t            in_data,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [lli_pkg::CNT_W-1:0]   cfg_wdata,
  input  lli_pkg::lli_cmd_t           cmd,
  output lli_pkg::lli_stat_t          stat,
  output logic                        out_valid,
  output lli_pkg::lli_out_t           out_data
);

  localparam int AW    = lli_pkg::AW;
  localparam int FW    = lli_pkg::FW;
  localparam int TW    = lli_pkg::TW;
  localparam int QW    = lli_pkg::QW;
  localparam int NW    = lli_pkg::NW;
  localparam int CNT_W = lli_pkg::CNT_W;

  logic [CNT_W-1:0]     cnt_r;
  logic                 fall_r;
  logic [FW-1:0]        v_r;
  logic [AW:0]          idx_r;
  logic                 hi_r;
  logic [FW-1:0]        prev_f_r, f0_r, f1_r;
  logic signed [TW-1:0] prev_t_r, t0_r, t1_r;
  logic signed [NW-1:0] num_r;
  logic signed [QW-1:0] den_r;
  logic                 out_valid_r;
  lli_pkg::lli_out_t    out_data_r, out_data_nxt;

  logic [AW-1:0]        last;
  logic [AW-1:0]        raddr;
  logic [AW:0]          didx;
  logic                 ram_we;
  logic [lli_pkg::RAM_W-1:0] rdata;
  logic [FW-1:0]        rd_f;
  logic signed [TW-1:0] rd_t;
  logic                 cond;
  logic                 hi_chk;
  logic signed [QW-1:0] dv, dt, den;
  logic                 div_done;
  logic signed [QW-1:0] quo;

  always_comb begin
    if (cnt_r < CNT_W'(2)) begin
      last = AW'(1);
    end else if (32'(cnt_r) > lli_pkg::TABLE_DEPTH) begin
      last = AW'(lli_pkg::TABLE_DEPTH - 1);
    end else begin
      last = AW'(cnt_r - CNT_W'(1));
    end
  end

  always_comb begin
    case (cmd.addr_sel)
      lli_pkg::ADDR_LAST: raddr = last;
      lli_pkg::ADDR_ZERO: raddr = '0;
      lli_pkg::ADDR_IDX:  raddr = idx_r[AW-1:0];
      default:            raddr = idx_r[AW-1:0];
    endcase
  end

  assign ram_we = cmd.ld_wr && (32'(in_data.entry_index) < lli_pkg::TABLE_DEPTH);

  lli_ram #(
    .WIDTH (lli_pkg::RAM_W),
    .DEPTH (lli_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_data.entry_index)),
    .wdata ({in_data.point_from, in_data.point_to}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_f   = rdata[FW+TW-1:TW];
  assign rd_t   = $signed(rdata[TW-1:0]);
  assign cond   = fall_r ? (v_r > rd_f) : (v_r < rd_f);
  assign hi_chk = fall_r ? (v_r < rd_f) : (v_r > rd_f);
  assign didx   = idx_r - (AW+1)'(1);

  assign stat.oor      = hi_r | cond;
  assign stat.hit      = cond;
  assign stat.at_last  = (didx[AW-1:0] == last);
  assign stat.div_done = div_done;

  assign dv  = $signed({1'b0, v_r}) - $signed({1'b0, f0_r});
  assign dt  = $signed({t1_r[TW-1], t1_r}) - $signed({t0_r[TW-1], t0_r});
  assign den = $signed({1'b0, f1_r}) - $signed({1'b0, f0_r});

  lli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= lli_pkg::COUNT_RESET;
      fall_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lli_pkg::CFG_ENTRY_COUNT: cnt_r  <= cfg_wdata;
        lli_pkg::CFG_SLOPE:       fall_r <= cfg_wdata[0];
        default:                  fall_r <= fall_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      v_r   <= in_data.measured_value;
      idx_r <= (AW+1)'(1);
    end else if (cmd.step) begin
      idx_r <= idx_r + (AW+1)'(1);
    end
    if (cmd.chk_hi) begin
      hi_r <= hi_chk;
    end
    if (cmd.step) begin
      prev_f_r <= rd_f;
      prev_t_r <= rd_t;
    end
    if (cmd.grab) begin
      f0_r <= prev_f_r;
      t0_r <= prev_t_r;
      f1_r <= rd_f;
      t1_r <= rd_t;
    end
    if (cmd.mul) begin
      num_r <= dv * dt;
      den_r <= den;
    end
  end

  always_comb begin
    out_data_nxt = out_data_r;
    case (cmd.emit)
      lli_pkg::RES_LOAD: begin
        out_data_nxt.converted_value = '0;
        out_data_nxt.status          = lli_pkg::STATUS_LOAD;
      end
      lli_pkg::RES_OOR: begin
        out_data_nxt.converted_value = '0;
        out_data_nxt.status          = lli_pkg::STATUS_OOR;
      end
      lli_pkg::RES_CONV: begin
        out_data_nxt.converted_value = (f1_r == f0_r) ? t0_r : t0_r + quo[TW-1:0];
        out_data_nxt.status          = lli_pkg::STATUS_CONV;
      end
      default: out_data_nxt = out_data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.emit != lli_pkg::RES_NONE);
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/lli_ctrl.sv
// Controller of the interpolator: sequences loads, the range check, the
// table search, the multiply and the divide, and issues result commands.
// Depends on lli_pkg.
module lli_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               opcode,
  input  lli_pkg::lli_stat_t stat,
  output lli_pkg::lli_cmd_t  cmd,
  output logic               busy
);

  lli_pkg::lli_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lli_pkg::ST_IDLE: begin
        if (start && opcode == lli_pkg::OP_CONV) begin
          state_nxt = lli_pkg::ST_LAST;
        end
      end
      lli_pkg::ST_LAST:  state_nxt = lli_pkg::ST_FIRST;
      lli_pkg::ST_FIRST: state_nxt = lli_pkg::ST_CHK0;
      lli_pkg::ST_CHK0: begin
        state_nxt = stat.oor ? lli_pkg::ST_IDLE : lli_pkg::ST_SCAN;
      end
      lli_pkg::ST_SCAN: begin
        if (stat.hit || stat.at_last) begin
          state_nxt = lli_pkg::ST_MUL;
        end
      end
      lli_pkg::ST_MUL:    state_nxt = lli_pkg::ST_DSTART;
      lli_pkg::ST_DSTART: state_nxt = lli_pkg::ST_DIV;
      lli_pkg::ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = lli_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lli_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{cap: 1'b0, ld_wr: 1'b0, addr_sel: lli_pkg::ADDR_IDX, chk_hi: 1'b0,
            step: 1'b0, grab: 1'b0, mul: 1'b0, div_start: 1'b0,
            emit: lli_pkg::RES_NONE};
    case (state_r)
      lli_pkg::ST_IDLE: begin
        if (start && opcode == lli_pkg::OP_LOAD) begin
          cmd.ld_wr = 1'b1;
          cmd.emit  = lli_pkg::RES_LOAD;
        end else if (start) begin
          cmd.cap = 1'b1;
        end
      end
      lli_pkg::ST_LAST: cmd.addr_sel = lli_pkg::ADDR_LAST;
      lli_pkg::ST_FIRST: begin
        cmd.addr_sel = lli_pkg::ADDR_ZERO;
        cmd.chk_hi   = 1'b1;
      end
      lli_pkg::ST_CHK0: begin
        if (stat.oor) begin
          cmd.emit = lli_pkg::RES_OOR;
        end else begin
          cmd.step = 1'b1;
        end
      end
      lli_pkg::ST_SCAN: begin
        if (stat.hit || stat.at_last) begin
          cmd.grab = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      lli_pkg::ST_MUL:    cmd.mul       = 1'b1;
      lli_pkg::ST_DSTART: cmd.div_start = 1'b1;
      lli_pkg::ST_DIV: begin
        if (stat.div_done) begin
          cmd.emit = lli_pkg::RES_CONV;
        end
      end
      default: cmd.emit = lli_pkg::RES_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lli_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != lli_pkg::ST_IDLE);

endmodule

// File: rtl/lut_linear_interpolator.sv
// Load item: result strobe in the cycle after acceptance; busy stays low.
// Convert item: the table search checks one entry a cycle until it finds the bracketing
// segment, then the multiply and the serial divide follow;
// an out-of-range value returns early, right after the range check.
// Reset is synchronous and active low: count 2, rising table, table contents undefined.
// Top level of the interpolator: joins the controller and the datapath.
// Depends on lli_pkg, lli_ctrl and lli_dp.
module lut_linear_interpolator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  lli_pkg::lli_in_t          in_data,
  output logic                      out_valid,
  output lli_pkg::lli_out_t         out_data,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [lli_pkg::CNT_W-1:0] cfg_wdata
);

  lli_pkg::lli_cmd_t  cmd;
  lli_pkg::lli_stat_t stat;
  logic               busy_w;
  logic               accept;

  assign accept = start && !busy_w;

  lli_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .opcode (in_data.opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy_w)
  );

  lli_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign busy = busy_w;

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.opcode == lli_pkg::OP_LOAD |=>
      out_valid && out_data.status == lli_pkg::STATUS_LOAD)
    else $error("Load item did not return a loaded status in the next cycle.");

  a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.opcode == lli_pkg::OP_CONV |=> busy && !out_valid)
    else $error("Convert item did not start the search.");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != lli_pkg::STATUS_CONV |-> out_data.converted_value == '0)
    else $error("Non-conversion result carries a non-zero value.");

endmodule

// File: dv/lli_checker.sv
// Checker for the LUT linear interpolator: watches the item, result and register ports,
// keeps its own copy of the breakpoint table and registers, and predicts every result.
// Depends on lli_pkg; hands its failure count and the number of awaited results upward.
module lli_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  lli_pkg::lli_in_t          in_data,
  input  logic                      out_valid,
  input  lli_pkg::lli_out_t         out_data,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [lli_pkg::CNT_W-1:0] cfg_wdata,
  output int                        pending_count,
  output int                        mismatch_total
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FW          = lli_pkg::FW;
  localparam int TW          = lli_pkg::TW;
  localparam int CNT_W       = lli_pkg::CNT_W;
  localparam int TABLE_DEPTH = lli_pkg::TABLE_DEPTH;

  logic [FW-1:0]        from_tbl [TABLE_DEPTH];
  logic signed [TW-1:0] to_tbl [TABLE_DEPTH];
  logic [CNT_W-1:0]     entry_count_q = lli_pkg::COUNT_RESET;
  logic                 falling_q = 1'b0;
  lli_pkg::lli_out_t    awaited_results [$];
  int                   failures = 0;
  int                   results_seen = 0;

  assign mismatch_total = failures;

  function automatic lli_pkg::lli_out_t linearize(input logic [FW-1:0] measured);
    lli_pkg::lli_out_t res;
    int       n;
    int       seg;
    int       i;
    bit       found;
    longint   v;
    longint   f;
    longint   f_lo;
    longint   f_hi;
    longint   t_lo;
    longint   t_hi;
    longint   quot;
    res = '0;
    n = entry_count_q;
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    v = longint'(measured);
    f_lo = longint'(from_tbl[0]);
    f_hi = longint'(from_tbl[n - 1]);
    if (falling_q ? (v > f_lo || v < f_hi) : (v < f_lo || v > f_hi)) begin
      res.status = lli_pkg::STATUS_OOR;
      return res;
    end
    seg = n - 1;
    found = 1'b0;
    for (i = 1; i < n; i++) begin
      f = longint'(from_tbl[i]);
      if (!found && (falling_q ? (v > f) : (v < f))) begin
        seg = i;
        found = 1'b1;
      end
    end
    f_lo = longint'(from_tbl[seg - 1]);
    f_hi = longint'(from_tbl[seg]);
    t_lo = longint'(to_tbl[seg - 1]);
    t_hi = longint'(to_tbl[seg]);
    quot = (f_hi == f_lo) ? 0 : ((v - f_lo) * (t_hi - t_lo)) / (f_hi - f_lo);
    res.converted_value = TW'(t_lo + quot);
    res.status = lli_pkg::STATUS_CONV;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    lli_pkg::lli_out_t want;
    lli_pkg::lli_out_t got;
    if (!rst_n) begin
      awaited_results.delete();
      entry_count_q = lli_pkg::COUNT_RESET;
      falling_q = 1'b0;
    end else begin
      got = out_data;
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          if (failures < 10)
            $display("result %0d arrived unexpectedly: converted_value %0d status %0d",
                     results_seen, got.converted_value, got.status);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          if (got.converted_value !== want.converted_value || got.status !== want.status) begin
            if (failures < 10)
              $display("result %0d: value expected %0d got %0d, status expected %0d got %0d",
                       results_seen, want.converted_value, got.converted_value,
                       want.status, got.status);
            failures++;
          end
        end
        results_seen++;
      end
      if (start && !busy) begin
        if (in_data.opcode == lli_pkg::OP_LOAD) begin
          from_tbl[in_data.entry_index] = in_data.point_from;
          to_tbl[in_data.entry_index] = in_data.point_to;
          want = '0;
          want.status = lli_pkg::STATUS_LOAD;
          awaited_results.push_back(want);
        end else begin
          awaited_results.push_back(linearize(in_data.measured_value));
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == lli_pkg::CFG_ENTRY_COUNT) begin
          entry_count_q = cfg_wdata;
        end else begin
          falling_q = cfg_wdata[0];
        end
      end
    end
    pending_count = awaited_results.size();
  end

endmodule

// File: dv/testbench.sv
// Top of the interpolator testbench: clock, reset, directed and random items and
// register settings, and the verdict. Depends on lli_pkg, lli_checker and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FW          = lli_pkg::FW;
  localparam int TW          = lli_pkg::TW;
  localparam int CNT_W       = lli_pkg::CNT_W;
  localparam int TABLE_DEPTH = lli_pkg::TABLE_DEPTH;

  typedef enum int {
    SPREAD,
    REPEATS,
    SCRAMBLED,
    FULL_SCALE
  } table_shape_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  lli_pkg::lli_in_t  in_data = '0;
  logic              out_valid;
  lli_pkg::lli_out_t out_data;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_index = lli_pkg::CFG_ENTRY_COUNT;
  logic [CNT_W-1:0]  cfg_wdata = '0;
  int                pending_count;
  int                mismatch_total;

  logic [FW-1:0]    tbl_from [TABLE_DEPTH];
  bit               idle_on = 1'b0;
  int               items_sent = 0;

  lut_linear_interpolator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lli_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .pending_count  (pending_count),
    .mismatch_total (mismatch_total)
  );

  always #10 clk = ~clk;

  function automatic int unsigned pick_gap();
    if (!idle_on) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 150);
    return $urandom_range(0, 3);
  endfunction

  function automatic int eff_count(input int count);
    if (count < 2) return 2;
    if (count > TABLE_DEPTH) return TABLE_DEPTH;
    return count;
  endfunction

  function automatic logic [FW-1:0] pick_measured(input int n);
    logic [FW-1:0] lo;
    logic [FW-1:0] hi;
    lo = tbl_from[0];
    hi = tbl_from[n - 1];
    if (lo > hi) begin
      lo = tbl_from[n - 1];
      hi = tbl_from[0];
    end
    case ($urandom_range(0, 9))
      0: return tbl_from[$urandom_range(0, n - 1)];
      1: return (lo == 0) ? lo : lo - 1'b1;
      2: return (hi == 24'hFFFFFF) ? hi : hi + 1'b1;
      3: return $urandom_range(0, 1) ? lo : hi;
      4: return FW'($urandom());
      default: return FW'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic send_item(input lli_pkg::lli_in_t item);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic send_load(input logic [5:0] index, input logic [FW-1:0] from_pt,
                           input logic [TW-1:0] to_pt);
    lli_pkg::lli_in_t item;
    item.opcode = lli_pkg::OP_LOAD;
    item.entry_index = index;
    item.point_from = from_pt;
    item.point_to = to_pt;
    item.measured_value = FW'($urandom());
    tbl_from[index] = from_pt;
    send_item(item);
  endtask

  task automatic send_convert(input logic [FW-1:0] measured);
    lli_pkg::lli_in_t item;
    item.opcode = lli_pkg::OP_CONV;
    item.entry_index = 6'($urandom());
    item.point_from = FW'($urandom());
    item.point_to = TW'($urandom());
    item.measured_value = measured;
    send_item(item);
  endtask

  task automatic set_config(input logic [CNT_W-1:0] count, input logic slope);
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0 || busy);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= lli_pkg::CFG_ENTRY_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_index <= lli_pkg::CFG_SLOPE;
    cfg_wdata <= (CNT_W'($urandom()) & ~CNT_W'(1)) | CNT_W'(slope);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_table(input int n, input logic falling, input table_shape_t shape);
    logic [FW-1:0] pts [TABLE_DEPTH];
    logic [TW-1:0] to_pt;
    int unsigned   stride_max;
    int            i;
    pts[0] = FW'($urandom());
    if (shape == FULL_SCALE) pts[0] = '0;
    else if (shape != SCRAMBLED) pts[0][FW-1] = 1'b0;
    stride_max = (24'hFFFFFF - pts[0]) / (n - 1);
    for (i = 1; i < n; i++) begin
      if (shape == SCRAMBLED) pts[i] = FW'($urandom());
      else if (shape == REPEATS && $urandom_range(0, 2) == 0) pts[i] = pts[i - 1];
      else pts[i] = pts[i - 1] + FW'($urandom_range(1, stride_max));
    end
    if (shape == REPEATS) pts[n - 1] = pts[n - 2];
    if (shape == FULL_SCALE) pts[n - 1] = 24'hFFFFFF;
    for (i = 0; i < n; i++) begin
      to_pt = (shape == FULL_SCALE) ? (i[0] ? 24'h7FFFFF : 24'h800000) : TW'($urandom());
      send_load(6'(falling ? n - 1 - i : i), pts[i], to_pt);
    end
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] count, input logic slope,
                           input table_shape_t shape, input int converts);
    int n;
    int i;
    set_config(count, slope);
    idle_on = ($urandom_range(0, 3) != 0);
    n = eff_count(count);
    load_table(n, slope, shape);
    for (i = 0; i < converts; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_load(6'($urandom()), FW'($urandom()), TW'($urandom()));
      end else begin
        send_convert(pick_measured(n));
      end
    end
  endtask

  initial begin
    int drain;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_load(6'd0, 24'h000000, 24'h800000);
    send_load(6'd1, 24'hFFFFFF, 24'h7FFFFF);
    send_convert(24'h000000);
    send_convert(24'hFFFFFF);
    send_convert(24'h800000);
    send_convert(24'h7FFFFF);
    send_load(6'd0, 24'h001000, 24'h000123);
    send_load(6'd1, 24'h001000, 24'hFFFF00);
    send_convert(24'h001000);
    send_convert(24'h000FFF);
    send_convert(24'h001001);
    set_config(CNT_W'(2), 1'b1);
    send_load(6'd0, 24'hF00000, -24'sd100);
    send_load(6'd1, 24'h000010, 24'sd2000);
    send_convert(24'hF00000);
    send_convert(24'h000010);
    send_convert(24'hF00001);
    send_convert(24'h00000F);
    send_convert(24'h123456);

    run_phase(CNT_W'(127), 1'b0, FULL_SCALE, 60);
    run_phase(CNT_W'(64), 1'b1, SPREAD, 60);
    run_phase(CNT_W'(0), 1'b0, REPEATS, 40);
    run_phase(CNT_W'(1), 1'b1, SPREAD, 40);
    run_phase(CNT_W'(65), 1'b1, REPEATS, 40);
    run_phase(CNT_W'(2), 1'b0, SCRAMBLED, 40);
    while (items_sent < 1520) begin
      run_phase(($urandom_range(0, 3) == 0) ? CNT_W'($urandom()) : CNT_W'($urandom_range(2, 16)),
                1'($urandom()), table_shape_t'($urandom_range(0, 3)), $urandom_range(40, 120));
    end

    start <= 1'b0;
    drain = 0;
    while ((pending_count != 0 || busy) && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (120) @(posedge clk);
    if (mismatch_total == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
